@@ hw/rtl/stl_pkg.sv @@
// stl_pkg: shared types and constants for the serialized trie term lookup
// no dependencies
package stl_pkg;

  localparam logic [7:0] FINAL_FLAG = 8'h01;
  localparam logic [7:0] MORE_BIT   = 8'h80;
  localparam logic [7:0] GROUP_MASK = 8'h7F;
  localparam int unsigned MAX_VARINT_BYTES = 10;
  localparam logic [16:0] BLOB_CAP = 17'd65536;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CHAR  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROOT_RD,    // issue reads of root bytes
    ST_ROOT_WAIT,
    ST_NODE_CNT,   // read arc count
    ST_ARC_LABEL,
    ST_ARC_VAR,
    ST_ARC_DONE,
    ST_FLAG_RD,
    ST_SKIP_CNT,
    ST_SKIP_LABEL,
    ST_SKIP_VAR,
    ST_INFO,
    ST_RESULT
  } stl_state_t;

  // memory request (read or write) from sequencer to memory
  typedef struct packed {
    logic        wr;
    logic        rd;
    logic [31:0] addr;
    logic [7:0]  wdata;
  } stl_mem_req_t;

endpackage

@@ hw/rtl/stl_mem.sv @@
// stl_mem: byte-wide trie memory, one port, read data registered
// depends on stl_pkg
module stl_mem #(
  parameter int unsigned MEMORY_BYTES = 65536
) (
  input  logic                 clk,
  input  stl_pkg::stl_mem_req_t req,
  output logic [7:0]           rdata
);
  import stl_pkg::*;

  localparam int unsigned AW = $clog2(MEMORY_BYTES);

  logic [7:0] mem [MEMORY_BYTES];

  // write or read; address wraps modulo the depth
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr[AW-1:0]];
    end
  end
endmodule

@@ hw/rtl/serialized_trie_term_lookup.sv @@
// serialized_trie_term_lookup: top level with the lookup sequencer
// depends on stl_pkg and stl_mem
//
// A write item is taken in the cycle it is offered: busy stays low and the
// next item can follow without waiting. A character walks the current node
// through a single-port byte memory, each byte read issued, then captured.
// It reads the arc count, then the label and varint bytes of each arc up to
// the matching label, the first greater one or the last arc; ST_ARC_DONE
// then takes the arc. The first character of a term reads the four root
// bytes and checks the root, unless the blob is under eight bytes. The last
// character ends in ST_RESULT; on a hit it reads the flag byte first and,
// for a final node, the arc count, every label and varint byte and sixteen
// term-info bytes. A character of a missed term goes to ST_ARC_DONE. Busy
// is high from the accepting edge until the character is done. result_valid
// shows the result for one cycle once busy is low; the receiver cannot stall it.
module serialized_trie_term_lookup #(
  parameter int unsigned MEMORY_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [15:0] address,
  input  logic [7:0]  byte_value,
  input  logic        last_char,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data,
  output logic        result_valid,
  output logic        found,
  output logic [31:0] doc_count,
  output logic [63:0] list_offset,
  output logic [31:0] list_length
);
  import stl_pkg::*;

  stl_state_t state, state_next;
  stl_mem_req_t req;
  logic [7:0] rdata;

  logic [16:0] blob_length;
  logic [15:0] node_offset;
  logic        term_started, term_missed;
  logic [7:0]  chr;
  logic        last_q;
  logic [31:0] pos;        // next read address
  logic        pend;       // read issued last cycle
  logic [7:0]  arcs_left;
  logic [7:0]  label_q;
  logic [63:0] vacc;
  logic [3:0]  vcnt;
  logic [4:0]  bcnt;
  logic [127:0] info;
  logic         hit;
  logic [63:0]  tgt;
  logic         var_end;
  logic         arc_miss;

  logic [16:0] eff_len;
  assign eff_len = (blob_length > BLOB_CAP) ? BLOB_CAP : blob_length;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;

  stl_mem #(.MEMORY_BYTES(MEMORY_BYTES)) u_mem (.clk(clk), .req(req), .rdata(rdata));

  assign tgt      = vacc | ({57'd0, rdata[6:0]} << (7 * vcnt));
  assign var_end  = !rdata[7] || vcnt == 4'(MAX_VARINT_BYTES - 1);
  assign arc_miss = term_missed || !hit || vacc >= {47'd0, eff_len};

  // memory request
  always_comb begin
    req = '0;
    if (state == ST_IDLE && start && action == ACT_WRITE) begin
      req.wr    = 1'b1;
      req.addr  = {16'd0, address};
      req.wdata = byte_value;
    end else if (state != ST_IDLE && state != ST_RESULT && state != ST_ARC_DONE
                 && state != ST_ROOT_WAIT && !pend) begin
      req.rd   = 1'b1;
      req.addr = pos;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && action == ACT_CHAR) begin
          if (!term_started) state_next = (eff_len < 17'd8) ? ST_ARC_DONE : ST_ROOT_RD;
          else if (term_missed) state_next = ST_ARC_DONE;
          else state_next = ST_NODE_CNT;
        end
      end
      ST_ROOT_RD: if (pend && bcnt == 5'd3) state_next = ST_ROOT_WAIT;
      ST_ROOT_WAIT: begin
        state_next = (vacc[31:0] >= {15'd0, eff_len}) ? ST_ARC_DONE : ST_NODE_CNT;
      end
      ST_NODE_CNT: if (pend) state_next = (rdata == 8'd0) ? ST_ARC_DONE : ST_ARC_LABEL;
      ST_ARC_LABEL: if (pend) state_next = ST_ARC_VAR;
      ST_ARC_VAR: begin
        if (pend && var_end) begin
          if (label_q >= chr || arcs_left == 8'd1) state_next = ST_ARC_DONE;
          else state_next = ST_ARC_LABEL;
        end
      end
      ST_ARC_DONE: begin
        if (!last_q) state_next = ST_IDLE;
        else if (arc_miss) state_next = ST_RESULT;
        else state_next = ST_FLAG_RD;
      end
      ST_FLAG_RD: begin
        if (pend) state_next = ((rdata & FINAL_FLAG) == 8'd0) ? ST_RESULT : ST_SKIP_CNT;
      end
      ST_SKIP_CNT: if (pend) state_next = (rdata == 8'd0) ? ST_INFO : ST_SKIP_LABEL;
      ST_SKIP_LABEL: if (pend) state_next = ST_SKIP_VAR;
      ST_SKIP_VAR: begin
        if (pend && var_end) state_next = (arcs_left == 8'd1) ? ST_INFO : ST_SKIP_LABEL;
      end
      ST_INFO: if (pend && bcnt == 5'd15) state_next = ST_RESULT;
      ST_RESULT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; blob_length <= '0; node_offset <= '0;
      term_started <= 1'b0; term_missed <= 1'b0; pend <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= (state == ST_RESULT);
      pend <= req.rd;
      if (cfg_valid && cfg_ready) blob_length <= cfg_data;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            chr <= byte_value; last_q <= last_char;
            if (action == ACT_CHAR) begin
              if (!term_started) begin
                term_started <= 1'b1;
                term_missed <= (eff_len < 17'd8);
                if (eff_len < 17'd8) begin
                  hit <= 1'b0;
                end else begin
                  pos <= 32'd4; bcnt <= '0; vacc <= '0;
                end
              end else if (term_missed) begin
                hit <= 1'b0;
              end else begin
                pos <= {16'd0, node_offset} + 32'd1;
              end
            end
          end
        end
        ST_ROOT_RD: if (pend) begin
          vacc <= vacc | ({56'd0, rdata} << (8 * bcnt[1:0]));
          pos <= pos + 32'd1; bcnt <= bcnt + 5'd1;
        end
        ST_ROOT_WAIT: begin
          // root in vacc[31:0]
          if (vacc[31:0] >= {15'd0, eff_len}) begin
            term_missed <= 1'b1; hit <= 1'b0;
          end else begin
            node_offset <= vacc[15:0];
            pos <= {16'd0, vacc[15:0]} + 32'd1;
          end
        end
        ST_NODE_CNT: if (pend) begin
          arcs_left <= rdata; pos <= pos + 32'd1; hit <= 1'b0;
        end
        ST_ARC_LABEL: if (pend) begin
          label_q <= rdata; pos <= pos + 32'd1; vacc <= '0; vcnt <= '0;
        end
        ST_ARC_VAR: if (pend) begin
          pos <= pos + 32'd1; vcnt <= vcnt + 4'd1; vacc <= tgt;
          if (var_end) begin
            arcs_left <= arcs_left - 8'd1;
            if (label_q == chr) hit <= 1'b1;
          end
        end
        ST_ARC_DONE: begin
          if (!term_missed) begin
            if (!hit || vacc >= {47'd0, eff_len}) term_missed <= 1'b1;
            else node_offset <= vacc[15:0];
          end
          if (last_q) begin
            if (arc_miss) begin
              info <= '0; found <= 1'b0;
            end else begin
              pos <= {16'd0, vacc[15:0]};
            end
          end
        end
        ST_FLAG_RD: if (pend) begin
          if ((rdata & FINAL_FLAG) == 8'd0) begin
            info <= '0; found <= 1'b0;
          end else begin
            found <= 1'b1; pos <= pos + 32'd1;
          end
        end
        ST_SKIP_CNT: if (pend) begin
          arcs_left <= rdata; pos <= pos + 32'd1; bcnt <= '0; info <= '0;
        end
        ST_SKIP_LABEL: if (pend) begin
          pos <= pos + 32'd1; vcnt <= '0;
        end
        ST_SKIP_VAR: if (pend) begin
          pos <= pos + 32'd1; vcnt <= vcnt + 4'd1;
          if (var_end) arcs_left <= arcs_left - 8'd1;
        end
        ST_INFO: if (pend) begin
          info <= {rdata, info[127:8]}; pos <= pos + 32'd1;
          bcnt <= bcnt + 5'd1;
        end
        ST_RESULT: begin
          term_started <= 1'b0; term_missed <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign doc_count   = info[31:0];
  assign list_offset = info[95:32];
  assign list_length = info[127:96];

  // a result never shows while busy is high
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy) else $error("result while busy");
  // a not-found result carries zero fields
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !found) |-> (doc_count == 32'd0 && list_offset == 64'd0
                                  && list_length == 32'd0))
    else $error("nonzero fields on miss");
  // results are single-cycle strobes
  a_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result held");
endmodule
